FILE: hw/rtl/ppmfd_pkg.sv
// Shared types and constants of the PPM frame decoder.
// No dependencies; used by every module of the block.
package ppmfd_pkg;

  localparam int CHANNEL_SLOTS = 8;
  localparam int MaxResults    = 8;

  localparam int SLOT_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
  localparam int CNT_W  = $clog2(CHANNEL_SLOTS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] SYNC_GAP_RST  = 16'd10000;
  localparam logic [15:0] PULSE_MIN_RST = 16'd1050;
  localparam logic [15:0] PULSE_MAX_RST = 16'd1950;
  localparam logic [3:0]  EXP_CH_RST    = 4'd8;

  typedef enum logic [1:0] {
    CFG_SYNC_GAP  = 2'd0,
    CFG_PULSE_MIN = 2'd1,
    CFG_PULSE_MAX = 2'd2,
    CFG_EXP_CH    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] sync_gap;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
  } win_cfg_t;

  typedef enum logic [1:0] {
    KIND_PULSE = 2'd0,
    KIND_BAD   = 2'd1,
    KIND_SYNC  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
  } edge_rec_t;

endpackage

FILE: hw/rtl/ppm_frame_decoder_unit.sv
// Top level of the PPM frame decoder: configuration registers, front end,
// record queue and back end. Depends on ppmfd_pkg and all ppmfd_* modules.
//
// One edge timestamp is taken per clock cycle while the queue is not full. The
// front end classifies the edge in the cycle it is accepted and writes it into a
// four-deep queue; the back end retires one queued edge per cycle while no frame
// drains. An accepted frame drains at one result beat per cycle while the consumer
// keeps popping; edges meanwhile collect in the queue, and in_full rises only
// when the queue is full. A closing edge passes through the queue and sets the
// drain flag before the first result is loaded. Results sit in an output register,
// so a stalled consumer stops the drain but not the intake until the queue fills.
module ppm_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_edge_time,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_channel_index,
  output logic [15:0] out_channel_value,
  output logic        out_last_channel,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wr_data
);

  ppmfd_pkg::win_cfg_t  win_r;
  logic [3:0]           exp_ch_r;
  logic                 q_wr, q_full, q_rd, q_empty;
  ppmfd_pkg::edge_rec_t q_wr_rec, q_rd_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.sync_gap  <= ppmfd_pkg::SYNC_GAP_RST;
      win_r.pulse_min <= ppmfd_pkg::PULSE_MIN_RST;
      win_r.pulse_max <= ppmfd_pkg::PULSE_MAX_RST;
      exp_ch_r        <= ppmfd_pkg::EXP_CH_RST;
    end else if (cfg_wr_en) begin
      unique case (ppmfd_pkg::cfg_idx_t'(cfg_index))
        ppmfd_pkg::CFG_SYNC_GAP:  win_r.sync_gap  <= cfg_wr_data;
        ppmfd_pkg::CFG_PULSE_MIN: win_r.pulse_min <= cfg_wr_data;
        ppmfd_pkg::CFG_PULSE_MAX: win_r.pulse_max <= cfg_wr_data;
        ppmfd_pkg::CFG_EXP_CH:    exp_ch_r        <= cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  ppmfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_edge_time (in_edge_time),
    .win_cfg      (win_r),
    .q_wr         (q_wr),
    .q_rec        (q_wr_rec),
    .q_full       (q_full)
  );

  ppmfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_rec (q_wr_rec),
    .full   (q_full),
    .rd     (q_rd),
    .rd_rec (q_rd_rec),
    .empty  (q_empty)
  );

  ppmfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rec             (q_rd_rec),
    .q_rd              (q_rd),
    .expected_channels (exp_ch_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_channel  (out_last_channel)
  );

endmodule

FILE: hw/rtl/ppmfd_front.sv
// Front end: takes edge timestamps, measures the interval and classifies it.
// Depends on ppmfd_pkg; feeds ppmfd_queue.
module ppmfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [31:0]          in_edge_time,
  input  ppmfd_pkg::win_cfg_t  win_cfg,
  output logic                 q_wr,
  output ppmfd_pkg::edge_rec_t q_rec,
  input  logic                 q_full
);

  // only the low half of the previous timestamp matters for a 16-bit interval
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] interval;
  logic        accept;

  assign accept   = in_push && !q_full;
  assign in_full  = q_full;
  assign q_wr     = accept;
  assign interval = in_edge_time[15:0] - prev_r;
  assign prev_nxt = accept ? in_edge_time[15:0] : prev_r;

  always_comb begin
    q_rec.value = interval;
    if (interval > win_cfg.sync_gap) begin
      q_rec.kind = ppmfd_pkg::KIND_SYNC;
    end else if (interval > win_cfg.pulse_min && interval < win_cfg.pulse_max) begin
      q_rec.kind = ppmfd_pkg::KIND_PULSE;
    end else begin
      q_rec.kind = ppmfd_pkg::KIND_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

FILE: hw/rtl/ppmfd_queue.sv
// Short queue of classified edge records between front and back end.
// Depends on ppmfd_pkg.
module ppmfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr,
  input  ppmfd_pkg::edge_rec_t wr_rec,
  output logic                 full,
  input  logic                 rd,
  output ppmfd_pkg::edge_rec_t rd_rec,
  output logic                 empty
);

  ppmfd_pkg::edge_rec_t             mem_r [ppmfd_pkg::QDEPTH];
  logic [ppmfd_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [ppmfd_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [ppmfd_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                             do_wr, do_rd;

  assign full   = (cnt_r == ppmfd_pkg::QCNT_W'(ppmfd_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_rec = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == ppmfd_pkg::QPTR_W'(ppmfd_pkg::QDEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == ppmfd_pkg::QPTR_W'(ppmfd_pkg::QDEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ppmfd_pkg::QCNT_W'(ppmfd_pkg::QDEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == ppmfd_pkg::QCNT_W'(ppmfd_pkg::QDEPTH)) |->
    (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: hw/rtl/ppmfd_back.sv
// Back end: collects pulses of a frame, checks the frame at the sync gap and
// drains an accepted frame one channel per beat. Depends on ppmfd_pkg.
module ppmfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  ppmfd_pkg::edge_rec_t q_rec,
  output logic                 q_rd,
  input  logic [3:0]           expected_channels,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_channel_index,
  output logic [15:0]          out_channel_value,
  output logic                 out_last_channel
);

  logic [15:0]                 store_r [ppmfd_pkg::CHANNEL_SLOTS];
  logic [ppmfd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        failed_r, failed_nxt;
  logic                        emit_r, emit_nxt;
  logic [ppmfd_pkg::SLOT_W-1:0] idx_r, idx_nxt;
  logic [ppmfd_pkg::SLOT_W-1:0] last_idx_r, last_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [2:0]                  out_idx_r, out_idx_nxt;
  logic [15:0]                 out_val_r, out_val_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        take, can_load, load, store_wr, frame_ok;

  assign take      = !emit_r && !q_empty;
  assign q_rd      = take;
  assign can_load  = !out_valid_r || out_pop;
  assign load      = emit_r && can_load;
  assign store_wr  = take && q_rec.kind == ppmfd_pkg::KIND_PULSE &&
                     int'(count_r) < ppmfd_pkg::CHANNEL_SLOTS;
  assign frame_ok  = !failed_r && int'(count_r) == int'(expected_channels) &&
                     int'(count_r) <= ppmfd_pkg::MaxResults && count_r != '0;

  always_comb begin
    count_nxt     = count_r;
    failed_nxt    = failed_r;
    emit_nxt      = emit_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (take) begin
      unique case (q_rec.kind)
        ppmfd_pkg::KIND_PULSE: begin
          if (store_wr) begin
            count_nxt = count_r + 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        ppmfd_pkg::KIND_SYNC: begin
          // store holds still while the frame drains: no pops until done
          if (frame_ok) begin
            emit_nxt     = 1'b1;
            idx_nxt      = '0;
            last_idx_nxt = ppmfd_pkg::SLOT_W'(count_r - 1'b1);
          end
          count_nxt  = '0;
          failed_nxt = 1'b0;
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = 3'(idx_r);
      out_val_nxt   = store_r[idx_r];
      out_last_nxt  = (idx_r == last_idx_r);
      if (idx_r == last_idx_r) begin
        emit_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      failed_r    <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      failed_r    <= failed_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    if (store_wr) begin
      store_r[count_r[ppmfd_pkg::SLOT_W-1:0]] <= q_rec.value;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_channel_value = out_val_r;
  assign out_last_channel  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= ppmfd_pkg::CHANNEL_SLOTS)
    else $error("pulse count beyond store size");

  a_no_pop_drain: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> !q_rd)
    else $error("queue popped while a frame drains");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && idx_r == last_idx_r) |=> (!emit_r && out_valid_r && out_last_r))
    else $error("drain did not end on the last channel");

  a_drain_clean: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> (count_r == '0 && !failed_r))
    else $error("frame state not cleared while draining");

endmodule
